[hw/rtl/dbio_pkg.sv]
// Shared types, codes and reset values for the debounced inputs / auto-off unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package dbio_pkg;

  // Field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DEBOUNCE_W = 16;
  localparam int unsigned SPAN_W     = 20;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Item op codes (code three is unused and ignored)
  localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
  localparam logic [OP_W-1:0] OP_SET      = 2'd1;
  localparam logic [OP_W-1:0] OP_SET_AUTO = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_DEBOUNCE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_DEBOUNCE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD           = 8'd3;

  // Register reset values
  localparam logic [DEBOUNCE_W-1:0] KEY_DEBOUNCE_RST   = 16'd50;
  localparam logic [SPAN_W-1:0]     LONG_PRESS_RST     = 20'd5000;
  localparam logic [DEBOUNCE_W-1:0] INPUT_DEBOUNCE_RST = 16'd30;
  localparam logic [SPAN_W-1:0]     HOLD_RST           = 20'd5000;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] key_settle_ms;
    logic [SPAN_W-1:0]     long_press_ms;
    logic [DEBOUNCE_W-1:0] input_debounce_ms;
    logic [SPAN_W-1:0]     hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] now_ms;
    logic              key_level;
    logic              input_level;
    logic              out_value;
  } item_t;

  typedef struct packed {
    logic out_level;
    logic key_held;
    logic long_press_event;
    logic input_state;
    logic input_changed;
  } result_t;

  // Wrap-safe check: now - since - span is non-negative as a signed value
  function automatic logic elapsed(input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] since,
                                   input logic [TIME_W-1:0] span);
    logic [TIME_W-1:0] diff;
    diff = now - since - span;
    return ~diff[TIME_W-1];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/dbio_cfg.sv]
// Configuration register file for the debounce and auto-off timings.
// Depends on dbio_pkg for register indexes, widths and reset values.
`default_nettype none

module dbio_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [dbio_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dbio_pkg::CFG_DATA_W-1:0]    cfg_data,
  output dbio_pkg::cfg_t                          cfg
);
  import dbio_pkg::*;

  logic wr;

  // Always ready: writes must only come while the block is idle; the block does not enforce it
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  // Store the written value masked to the register width; drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_settle_ms     <= KEY_DEBOUNCE_RST;
      cfg.long_press_ms     <= LONG_PRESS_RST;
      cfg.input_debounce_ms <= INPUT_DEBOUNCE_RST;
      cfg.hold_ms           <= HOLD_RST;
    end else if (wr) begin
      unique case (cfg_index)
        CFG_KEY_DEBOUNCE:   cfg.key_settle_ms     <= cfg_data[DEBOUNCE_W-1:0];
        CFG_LONG_PRESS:     cfg.long_press_ms     <= cfg_data[SPAN_W-1:0];
        CFG_INPUT_DEBOUNCE: cfg.input_debounce_ms <= cfg_data[DEBOUNCE_W-1:0];
        CFG_HOLD:           cfg.hold_ms           <= cfg_data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dbio_core.sv]
// Debounce, long-press and auto-off state with its single-pass update logic.
// Depends on dbio_pkg for item, result and configuration types.
`default_nettype none

module dbio_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  dbio_pkg::item_t      item,
  input  dbio_pkg::cfg_t       cfg,
  output dbio_pkg::result_t    res
);
  import dbio_pkg::*;

  logic              key_state, key_state_next;
  logic [TIME_W-1:0] key_change_time, key_change_time_next;
  logic [TIME_W-1:0] press_start_time, press_start_time_next;
  logic              long_press_reported, long_press_reported_next;
  logic [TIME_W-1:0] off_deadline, off_deadline_next;
  logic              out_reg, out_reg_next;
  logic              input_cached, input_cached_next;
  logic [TIME_W-1:0] input_change_time, input_change_time_next;
  logic              lp_event, in_event;
  logic              pressed, active;

  assign pressed = ~item.key_level;
  assign active  = ~item.input_level;

  // Work out the next state for one item
  always_comb begin
    key_state_next           = key_state;
    key_change_time_next     = key_change_time;
    press_start_time_next    = press_start_time;
    long_press_reported_next = long_press_reported;
    off_deadline_next        = off_deadline;
    out_reg_next             = out_reg;
    input_cached_next        = input_cached;
    input_change_time_next   = input_change_time;
    lp_event                 = 1'b0;
    in_event                 = 1'b0;
    if (en) begin
      unique case (item.op)
        OP_TICK: begin
          // Key debounce, then long press once per hold
          if (pressed != key_state) begin
            if (elapsed(item.now_ms, key_change_time,
                        {{(TIME_W-DEBOUNCE_W){1'b0}}, cfg.key_settle_ms})) begin
              key_change_time_next     = item.now_ms;
              if (pressed) begin
                press_start_time_next = item.now_ms;
              end
              key_state_next           = pressed;
              long_press_reported_next = 1'b0;
            end
          end else if (pressed && !long_press_reported) begin
            if (elapsed(item.now_ms, press_start_time,
                        {{(TIME_W-SPAN_W){1'b0}}, cfg.long_press_ms})) begin
              lp_event                 = 1'b1;
              long_press_reported_next = 1'b1;
            end
          end
          // Drop the output once an armed deadline has passed
          if (off_deadline != '0 && elapsed(item.now_ms, off_deadline, '0)) begin
            out_reg_next      = 1'b0;
            off_deadline_next = '0;
          end
          // Digital input debounce
          if (active != input_cached) begin
            if (elapsed(item.now_ms, input_change_time,
                        {{(TIME_W-DEBOUNCE_W){1'b0}}, cfg.input_debounce_ms})) begin
              input_cached_next      = active;
              input_change_time_next = item.now_ms;
              in_event               = 1'b1;
            end
          end
        end
        OP_SET: begin
          out_reg_next = item.out_value;
          if (!item.out_value) begin
            off_deadline_next = '0;
          end
        end
        OP_SET_AUTO: begin
          out_reg_next = item.out_value;
          if (item.out_value) begin
            off_deadline_next = item.now_ms + {{(TIME_W-SPAN_W){1'b0}}, cfg.hold_ms};
          end else begin
            off_deadline_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Result reflects the state after this item
  always_comb begin
    res.out_level        = out_reg_next;
    res.key_held         = key_state_next;
    res.long_press_event = lp_event;
    res.input_state      = input_cached_next;
    res.input_changed    = in_event;
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      key_state           <= 1'b0;
      key_change_time     <= '0;
      press_start_time    <= '0;
      long_press_reported <= 1'b0;
      off_deadline        <= '0;
      out_reg             <= 1'b0;
      input_cached        <= 1'b0;
      input_change_time   <= '0;
    end else begin
      key_state           <= key_state_next;
      key_change_time     <= key_change_time_next;
      press_start_time    <= press_start_time_next;
      long_press_reported <= long_press_reported_next;
      off_deadline        <= off_deadline_next;
      out_reg             <= out_reg_next;
      input_cached        <= input_cached_next;
      input_change_time   <= input_change_time_next;
    end
  end

  // An armed deadline always goes with a high output
  a_armed_high: assert property (@(posedge clk) disable iff (rst)
    off_deadline != '0 |-> out_reg)
    else $error("auto-off deadline armed while output is low");

  // A long press only fires with the key held
  a_lp_held: assert property (@(posedge clk) disable iff (rst)
    lp_event |-> key_state && key_state_next)
    else $error("long press flagged without a held key");

  // Set ops and idle cycles raise no events
  a_no_event: assert property (@(posedge clk) disable iff (rst)
    (!en || item.op != OP_TICK) |-> !lp_event && !in_event)
    else $error("event raised outside a tick");

  // A long press is reported once per hold
  a_lp_once: assert property (@(posedge clk) disable iff (rst)
    lp_event |=> long_press_reported)
    else $error("long press not marked as reported");

endmodule

`default_nettype wire

[hw/rtl/debounced_inputs_with_auto_off_output_unit.sv]
// Top level of the debounced key / digital input unit with auto-off output.
// Depends on dbio_pkg, dbio_cfg and dbio_core.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    op, now_ms, key_level, input_level, out_value
//   out      source     out_valid / out_stall  out_level, key_held, long_press_event,
//                                              input_state, input_changed
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; an item goes first into the input
// register, and its result (one-pass state update) then goes into the result register,
// which raises out_valid.
// Reset (rst, synchronous) restores the timing registers and clears core state and valids.
// While out_stall holds, one more item is taken into the input register, then
// in_stall rises until the waiting result is transferred.
// cfg_ready is always high.
`default_nettype none

module debounced_inputs_with_auto_off_output_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [dbio_pkg::OP_W-1:0]          op,
  input  wire logic [dbio_pkg::TIME_W-1:0]        now_ms,
  input  wire logic                               key_level,
  input  wire logic                               input_level,
  input  wire logic                               out_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_level,
  output logic                                    key_held,
  output logic                                    long_press_event,
  output logic                                    input_state,
  output logic                                    input_changed,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [dbio_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dbio_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dbio_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  result_t res;
  result_t result;
  logic    advance;

  dbio_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Move the held item on when the result register is free or draining
  assign advance  = ~out_valid | ~out_stall;
  assign in_stall = item_valid & ~advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.op          <= op;
      item.now_ms      <= now_ms;
      item.key_level   <= key_level;
      item.input_level <= input_level;
      item.out_value   <= out_value;
    end
  end

  dbio_core u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (item_valid & advance),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && advance) begin
      result <= res;
    end
  end

  assign out_level        = result.out_level;
  assign key_held         = result.key_held;
  assign long_press_event = result.long_press_event;
  assign input_state      = result.input_state;
  assign input_changed    = result.input_changed;

  // A processed item always lands in the result register
  a_item_lands: assert property (@(posedge clk) disable iff (rst)
    item_valid && advance |=> out_valid)
    else $error("processed item lost before the result register");

  // Backpressure only with both registers full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // A stalled item stays in the input register
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> item_valid && $stable(item))
    else $error("held item changed while stalled");

endmodule

`default_nettype wire
